// File: design/hsa_pkg.sv
// Package for the hexagonal spiral address adder: widths, defaults, the
// sequencer state type, the 7x7 digit addition table and digit helper functions.
// No dependencies; every other design file imports it.
`default_nettype none

package hsa_pkg;

  localparam int ADDR_W     = 34;
  localparam int DK_W       = 4;
  localparam int DIGITS_DEF = 12;
  localparam int CONV_BITS  = 2;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [DK_W-1:0] DK_RESET = DK_W'(12);
  localparam logic            REG_DIGITS_KEPT = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_ADD,
    S_RIPPLE,
    S_PACK,
    S_DONE
  } hsa_state_t;

  typedef struct packed {
    logic [2:0] carry;
    logic [2:0] digit;
  } digit_pair_t;

  // Each entry holds the carry digit in the upper octal place and the sum digit below.
  localparam logic [5:0] ADD_TABLE [7][7] = '{
    '{6'o00, 6'o01, 6'o02, 6'o03, 6'o04, 6'o05, 6'o06},
    '{6'o01, 6'o63, 6'o15, 6'o02, 6'o00, 6'o06, 6'o64},
    '{6'o02, 6'o15, 6'o14, 6'o26, 6'o03, 6'o00, 6'o01},
    '{6'o03, 6'o02, 6'o26, 6'o25, 6'o31, 6'o04, 6'o00},
    '{6'o04, 6'o00, 6'o03, 6'o31, 6'o36, 6'o42, 6'o05},
    '{6'o05, 6'o06, 6'o00, 6'o04, 6'o42, 6'o41, 6'o53},
    '{6'o06, 6'o64, 6'o01, 6'o00, 6'o05, 6'o53, 6'o52}
  };

  function automatic digit_pair_t hsa_lookup(input logic [2:0] a, input logic [2:0] b);
    digit_pair_t r;
    r = '0;
    if (a != 3'd7 && b != 3'd7) begin
      r = digit_pair_t'(ADD_TABLE[a][b]);
    end
    return r;
  endfunction

  // One base-7 digit of a doubling step: returns {carry out, new digit}.
  function automatic logic [3:0] dd_digit(input logic [2:0] d, input logic cin);
    logic [3:0] v;
    logic [3:0] r;
    v = {d, 1'b0} + {3'b000, cin};
    if (v >= 4'd7) begin
      r = {1'b1, 3'(v - 4'd7)};
    end else begin
      r = {1'b0, v[2:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/hsa_if.sv
// Channel interfaces of the hexagonal spiral address adder: operand input and
// sum output, each with valid, ready and payload. Depends on hsa_pkg.
`default_nettype none

interface hsa_in_if import hsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] addend_a;
  logic [ADDR_W-1:0] addend_b;

  modport source (output valid, output addend_a, output addend_b, input ready);
  modport sink   (input valid, input addend_a, input addend_b, output ready);
endinterface

interface hsa_out_if import hsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address_sum;

  modport source (output valid, output address_sum, input ready);
  modport sink   (input valid, input address_sum, output ready);
endinterface

`default_nettype wire

// File: design/hsa_apb_regs.sv
// APB-style configuration register block holding digits_kept.
// Depends on hsa_pkg.
`default_nettype none

module hsa_apb_regs import hsa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output logic      [DK_W-1:0]   digits_kept
);

  logic [DK_W-1:0] digits_kept_r;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_DIGITS_KEPT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digits_kept_r <= DK_RESET;
    end else if (wr_en) begin
      digits_kept_r <= pwdata[DK_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_DIGITS_KEPT) begin
      prdata = {{(APB_DW-DK_W){1'b0}}, digits_kept_r};
    end
  end

  assign digits_kept = digits_kept_r;

endmodule

`default_nettype wire

// File: design/hsa_core.sv
// Sequencer and shared datapath: binary to base-7 conversion, table addition with
// carry ripple through one shared table lookup, and Horner repacking. Uses hsa_pkg, hsa_if.
`default_nettype none

module hsa_core import hsa_pkg::*; #(
  parameter int DIGITS = DIGITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [DK_W-1:0] digits_kept,
  hsa_in_if.sink               in_ch,
  hsa_out_if.source            out_ch
);

  localparam int IW       = $clog2(DIGITS);
  localparam int STEP_CNT = ADDR_W / CONV_BITS;
  localparam int SW       = $clog2(STEP_CNT);
  localparam logic [IW-1:0] TOP_IDX  = IW'(DIGITS - 1);
  localparam logic [SW-1:0] STEP_TOP = SW'(STEP_CNT - 1);

  hsa_state_t state_r;
  hsa_state_t state_nxt;

  logic [2:0]        da_r [DIGITS];
  logic [2:0]        db_r [DIGITS];
  logic [2:0]        res_r [DIGITS];
  logic [ADDR_W-1:0] sa_r;
  logic [ADDR_W-1:0] sb_r;
  logic [SW-1:0]     step_r;
  logic [IW-1:0]     i_r;
  logic [IW-1:0]     j_r;
  logic [2:0]        carry_r;
  logic [ADDR_W-1:0] acc_r;
  logic [ADDR_W-1:0] out_data_r;
  logic              out_valid_r;

  logic [2:0]        conv_a [DIGITS];
  logic [2:0]        conv_b [DIGITS];
  logic              ca_c;
  logic              cb_c;
  logic [2:0]        lk_a;
  logic [2:0]        lk_b;
  digit_pair_t       lk;
  logic              add_ripple;
  logic              rip_more;
  logic [2:0]        pack_digit;
  logic [ADDR_W-1:0] acc_nxt;
  logic              out_load;

  // Doubling steps of the base-7 digit vectors, one operand bit per step.
  always_comb begin
    ca_c = 1'b0;
    cb_c = 1'b0;
    for (int g = 0; g < DIGITS; g++) begin
      conv_a[g] = da_r[g];
      conv_b[g] = db_r[g];
    end
    for (int k = 0; k < CONV_BITS; k++) begin
      ca_c = sa_r[ADDR_W-1-k];
      cb_c = sb_r[ADDR_W-1-k];
      for (int g = 0; g < DIGITS; g++) begin
        {ca_c, conv_a[g]} = dd_digit(conv_a[g], ca_c);
        {cb_c, conv_b[g]} = dd_digit(conv_b[g], cb_c);
      end
    end
  end

  always_comb begin
    if (state_r == S_RIPPLE) begin
      lk_a = da_r[j_r];
      lk_b = carry_r;
    end else begin
      lk_a = da_r[i_r];
      lk_b = db_r[i_r];
    end
    lk = hsa_lookup(lk_a, lk_b);
  end

  assign add_ripple = (lk.carry != 3'd0) && (i_r != TOP_IDX);
  assign rip_more   = (lk.carry != 3'd0) && (j_r != TOP_IDX);
  assign pack_digit = (32'(i_r) < 32'(digits_kept)) ? res_r[i_r] : 3'd0;
  assign acc_nxt    = (acc_r << 3) - acc_r + ADDR_W'(pack_digit);
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        if (step_r == '0) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        if (add_ripple) begin
          state_nxt = S_RIPPLE;
        end else if (i_r == TOP_IDX) begin
          state_nxt = S_PACK;
        end
      end
      S_RIPPLE: begin
        if (!rip_more) begin
          state_nxt = S_ADD;
        end
      end
      S_PACK: begin
        if (i_r == '0) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= acc_r;
    end
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          sa_r   <= in_ch.addend_a;
          sb_r   <= in_ch.addend_b;
          step_r <= STEP_TOP;
          i_r    <= '0;
          for (int g = 0; g < DIGITS; g++) begin
            da_r[g] <= 3'd0;
            db_r[g] <= 3'd0;
          end
        end
      end
      S_CONV: begin
        sa_r   <= sa_r << CONV_BITS;
        sb_r   <= sb_r << CONV_BITS;
        step_r <= step_r - 1'b1;
        for (int g = 0; g < DIGITS; g++) begin
          da_r[g] <= conv_a[g];
          db_r[g] <= conv_b[g];
        end
      end
      S_ADD: begin
        res_r[i_r] <= lk.digit;
        carry_r    <= lk.carry;
        j_r        <= i_r + 1'b1;
        acc_r      <= '0;
        if (!add_ripple && (i_r != TOP_IDX)) begin
          i_r <= i_r + 1'b1;
        end
      end
      S_RIPPLE: begin
        da_r[j_r] <= lk.digit;
        carry_r   <= lk.carry;
        j_r       <= j_r + 1'b1;
        if (!rip_more) begin
          i_r <= i_r + 1'b1;
        end
      end
      S_PACK: begin
        acc_r <= acc_nxt;
        i_r   <= i_r - 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.address_sum = out_data_r;

endmodule

`default_nettype wire

// File: design/hex_spiral_address_adder_unit.sv
// Hexagonal spiral address adder, top level. A transaction passes through acceptance,
// binary to base-7 conversion, table addition of the DIGITS digit pairs with a ripple
// step for each carry to propagate, Horner repacking of the DIGITS digits and output,
// one transaction at a time through the shared table.
// Reset (synchronous, rst_n low) idles the sequencer, drops the output valid and sets
// digits_kept to 12. Depends on hsa_pkg, hsa_if, hsa_apb_regs and hsa_core.
`default_nettype none

module hex_spiral_address_adder_unit import hsa_pkg::*; #(
  parameter int DIGITS = DIGITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  hsa_in_if.sink                 in_ch,
  hsa_out_if.source              out_ch
);

  logic [DK_W-1:0] digits_kept;

  hsa_apb_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .digits_kept (digits_kept)
  );

  hsa_core #(
    .DIGITS (DIGITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .digits_kept (digits_kept),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire
